// File: design/vidreg_pkg.sv
// Shared types, port addresses and constants of the display adapter register file.
package vidreg_pkg;

    // Field and register widths.
    localparam int PORT_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int OP_W       = 2;
    localparam int CYCLE_W    = 64;
    localparam int PERIOD_W   = 19;
    localparam int CFG_IDX_W  = 2;
    localparam int ATTR_SEL_W = 5;

    // Credit arithmetic: 3 * (64-bit delta) + 19-bit credit fits in 67 bits.
    localparam int DIVIDEND_W = CYCLE_W + 3;
    localparam int STEP_CNT_W = $clog2(DIVIDEND_W);

    // Every bank select input is one byte wide, so bank index tables span 256 codes.
    localparam int SEL_SPAN = 1 << BYTE_W;

    // Default bank sizes.
    localparam int CRTC_REGS_DEF      = 32;
    localparam int SEQUENCER_REGS_DEF = 8;
    localparam int GRAPHICS_REGS_DEF  = 16;
    localparam int ATTRIBUTE_REGS_DEF = 32;

    // Operation codes of an input transaction.
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRACE_WINDOW = 2'd1;

    // Configuration reset values.
    localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RST   = 19'd400000;
    localparam logic [PERIOD_W-1:0] RETRACE_WINDOW_RST = 19'd32000;

    // Owned I/O ports.
    localparam logic [PORT_W-1:0] PORT_ATTR_IDX  = 16'h03C0;
    localparam logic [PORT_W-1:0] PORT_ATTR_DATA = 16'h03C1;
    localparam logic [PORT_W-1:0] PORT_MISC_WR   = 16'h03C2;
    localparam logic [PORT_W-1:0] PORT_SEQ_IDX   = 16'h03C4;
    localparam logic [PORT_W-1:0] PORT_SEQ_DATA  = 16'h03C5;
    localparam logic [PORT_W-1:0] PORT_MISC_RD   = 16'h03CC;
    localparam logic [PORT_W-1:0] PORT_GFX_IDX   = 16'h03CE;
    localparam logic [PORT_W-1:0] PORT_GFX_DATA  = 16'h03CF;
    localparam logic [PORT_W-1:0] PORT_CRTC_IDX  = 16'h03D4;
    localparam logic [PORT_W-1:0] PORT_CRTC_DATA = 16'h03D5;
    localparam logic [PORT_W-1:0] PORT_STATUS    = 16'h03DA;

    // Read values and masks.
    localparam logic [BYTE_W-1:0] STATUS_RETRACE  = 8'h08;
    localparam logic [BYTE_W-1:0] STATUS_ACTIVE   = 8'h00;
    localparam logic [BYTE_W-1:0] ATTR_INDEX_MASK = 8'h1F;
    localparam logic [BYTE_W-1:0] UNOWNED_READ    = 8'hFF;
    localparam logic [BYTE_W-1:0] ZERO_BYTE       = 8'h00;

    // Request to one register bank.
    typedef struct packed {
        logic              we;
        logic [BYTE_W-1:0] sel;
        logic [BYTE_W-1:0] wdata;
    } bank_req_t;

    // Command to the remainder unit.
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [PERIOD_W-1:0]   divisor;
    } rem_cmd_t;

    // Status of the remainder unit.
    typedef struct packed {
        logic                done;
        logic [PERIOD_W-1:0] remainder;
    } rem_sts_t;

    // True for every port that the adapter decodes.
    function automatic logic is_owned(input logic [PORT_W-1:0] port);
        logic hit;
        hit = 1'b0;
        case (port)
            PORT_ATTR_IDX, PORT_ATTR_DATA, PORT_MISC_WR, PORT_SEQ_IDX, PORT_SEQ_DATA,
            PORT_MISC_RD, PORT_GFX_IDX, PORT_GFX_DATA, PORT_CRTC_IDX, PORT_CRTC_DATA,
            PORT_STATUS: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// File: design/vidreg_if.sv
// Handshake channels for port and tick transactions and for their results.
interface vidreg_req_if;
    logic                           valid;
    logic                           ready;
    logic [vidreg_pkg::OP_W-1:0]    op;
    logic [vidreg_pkg::PORT_W-1:0]  port;
    logic [vidreg_pkg::BYTE_W-1:0]  data;
    logic [vidreg_pkg::CYCLE_W-1:0] cycle_count;

    modport source (output valid, output op, output port, output data, output cycle_count,
                    input ready);
    modport sink (input valid, input op, input port, input data, input cycle_count,
                  output ready);
endinterface

interface vidreg_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [vidreg_pkg::BYTE_W-1:0] read_data;
    logic                          port_owned;

    modport source (output valid, output read_data, output port_owned, input ready);
    modport sink (input valid, input read_data, input port_owned, output ready);
endinterface

// File: design/vidreg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vidreg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: design/vidreg_bank.sv
// One indexed register bank: select wrap-around, storage and written-entry tracking.
module vidreg_bank #(
    parameter int DEPTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  vidreg_pkg::bank_req_t         req,
    output logic [vidreg_pkg::BYTE_W-1:0] rdata
);
    import vidreg_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [AW-1:0]     wrap_tab [SEL_SPAN];
    logic [AW-1:0]     idx;
    logic [DEPTH-1:0]  valid_reg;
    logic              rd_valid_reg;
    logic [BYTE_W-1:0] ram_q;

    // Constant table of select values taken modulo the bank size.
    for (genvar g = 0; g < SEL_SPAN; g++)
    begin : g_wrap
        localparam int unsigned WRAPPED = g % DEPTH;
        assign wrap_tab[g] = AW'(WRAPPED);
    end

    assign idx = wrap_tab[req.sel];

    vidreg_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (req.we),
        .waddr (idx),
        .wdata (req.wdata),
        .raddr (idx),
        .rdata (ram_q)
    );

    // Entries never written read as zero; the flag is registered with the read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[idx];
            if (req.we)
            begin
                valid_reg[idx] <= 1'b1;
            end
        end
    end

    assign rdata = rd_valid_reg ? ram_q : ZERO_BYTE;
endmodule

// File: design/vidreg_rem.sv
// Iterative restoring remainder unit: one shift-subtract step per cycle.
module vidreg_rem (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vidreg_pkg::rem_cmd_t cmd,
    output vidreg_pkg::rem_sts_t sts
);
    import vidreg_pkg::*;

    localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(DIVIDEND_W - 1);

    logic [DIVIDEND_W-1:0] x_reg;
    logic [PERIOD_W-1:0]   rem_reg;
    logic [PERIOD_W-1:0]   div_reg;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic                  run_reg;
    logic                  done_reg;
    logic [PERIOD_W:0]     trial;
    logic [PERIOD_W:0]     diff;
    logic [PERIOD_W-1:0]   rem_next;

    // Bring down the next dividend bit and subtract the divisor when it fits.
    always_comb
    begin
        trial    = {rem_reg, x_reg[DIVIDEND_W-1]};
        diff     = trial - {1'b0, div_reg};
        rem_next = (trial >= {1'b0, div_reg}) ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
    end

    // Step control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= LAST_STEP;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_reg   <= cmd.dividend;
            rem_reg <= '0;
            div_reg <= cmd.divisor;
        end
        else if (run_reg)
        begin
            x_reg   <= {x_reg[DIVIDEND_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign sts.done      = done_reg;
    assign sts.remainder = rem_reg;

    // The partial remainder stays below the divisor throughout a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg && !cmd.start) |-> (rem_reg < div_reg))
    else $error("partial remainder not below divisor");

    // Completion is reported exactly once, right after the last step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg && !cmd.start && cnt_reg == '0) |=> (done_reg && !run_reg))
    else $error("remainder unit missed its completion");
endmodule

// File: design/video_adapter_register_file.sv
// Top level of the display adapter I/O register file.
//
//  Channel  Direction  Handshake        Contents
//  req      in         valid/ready      op, port, data, cycle_count
//  rsp      out        valid/ready      read_data, port_owned
//  cfg      in         cfg_we           cfg_index, cfg_data (no read-back)
//
// A port read or write passes through S_ACCESS, which loads the result register, to S_RESP.
// A tick steps through S_DELTA, S_TRIPLE and S_CREDIT for the 64-bit delta, tripling and credit add,
// then 67 shift-subtract steps of the remainder unit, then the retrace compare.
// One transaction is in flight at a time; req.ready is high only while idle.
// A result waiting in the output register holds the sequencer until rsp takes it.
// Reset clears all control state and the bank written-entry flags; no clearing pass.
module video_adapter_register_file #(
    parameter int CRTC_REGS      = vidreg_pkg::CRTC_REGS_DEF,
    parameter int SEQUENCER_REGS = vidreg_pkg::SEQUENCER_REGS_DEF,
    parameter int GRAPHICS_REGS  = vidreg_pkg::GRAPHICS_REGS_DEF,
    parameter int ATTRIBUTE_REGS = vidreg_pkg::ATTRIBUTE_REGS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    vidreg_req_if.sink                       req,
    vidreg_rsp_if.source                     rsp,
    input  logic                             cfg_we,
    input  logic [vidreg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vidreg_pkg::PERIOD_W-1:0]  cfg_data
);
    import vidreg_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ACCESS = 7'b0000010,
        S_DELTA  = 7'b0000100,
        S_TRIPLE = 7'b0001000,
        S_CREDIT = 7'b0010000,
        S_DIVIDE = 7'b0100000,
        S_RESP   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration.
    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] window_reg;
    logic [PERIOD_W-1:0] period_eff;

    // Captured transaction.
    logic [OP_W-1:0]    op_reg;
    logic [PORT_W-1:0]  port_reg;
    logic [BYTE_W-1:0]  data_reg;
    logic [CYCLE_W-1:0] cycle_reg;

    // Architectural state outside the banks.
    logic [BYTE_W-1:0]     crtc_sel_reg;
    logic [BYTE_W-1:0]     seq_sel_reg;
    logic [BYTE_W-1:0]     gfx_sel_reg;
    logic [ATTR_SEL_W-1:0] attr_sel_reg;
    logic                  expect_index_reg;
    logic [BYTE_W-1:0]     misc_reg;
    logic                  retrace_reg;
    logic [CYCLE_W-1:0]    last_cycle_reg;
    logic [PERIOD_W-1:0]   credit_reg;

    // Tick working value and result staging.
    logic [CYCLE_W-1:0]    tick_delta;
    logic [DIVIDEND_W-1:0] wide_reg;
    logic [BYTE_W-1:0]     res_data_reg;
    logic                  res_owned_reg;
    logic                  out_valid_reg;
    logic [BYTE_W-1:0]     out_data_reg;
    logic                  out_owned_reg;

    bank_req_t         crtc_req;
    bank_req_t         seq_req;
    bank_req_t         gfx_req;
    bank_req_t         attr_req;
    logic [BYTE_W-1:0] crtc_q;
    logic [BYTE_W-1:0] seq_q;
    logic [BYTE_W-1:0] gfx_q;
    logic [BYTE_W-1:0] attr_q;
    rem_cmd_t          rem_cmd;
    rem_sts_t          rem_sts;

    logic              accept;
    logic              is_write;
    logic              out_free;
    logic [BYTE_W-1:0] read_value;

    assign accept     = req.valid && req.ready;
    assign is_write   = (state_reg == S_ACCESS) && (op_reg == OP_WRITE);
    assign out_free   = !out_valid_reg || rsp.ready;
    assign period_eff = (period_reg == '0) ? PERIOD_W'(1) : period_reg;

    // The cycle delta wraps at 64 bits before it is widened.
    assign tick_delta = cycle_reg - last_cycle_reg;

    // Bank requests: writes happen in the access cycle only.
    always_comb
    begin
        crtc_req.we    = is_write && (port_reg == PORT_CRTC_DATA);
        crtc_req.sel   = crtc_sel_reg;
        crtc_req.wdata = data_reg;
        seq_req.we     = is_write && (port_reg == PORT_SEQ_DATA);
        seq_req.sel    = seq_sel_reg;
        seq_req.wdata  = data_reg;
        gfx_req.we     = is_write && (port_reg == PORT_GFX_DATA);
        gfx_req.sel    = gfx_sel_reg;
        gfx_req.wdata  = data_reg;
        attr_req.we    = is_write && (port_reg == PORT_ATTR_IDX) && !expect_index_reg;
        attr_req.sel   = BYTE_W'(attr_sel_reg);
        attr_req.wdata = data_reg;
    end

    vidreg_bank #(.DEPTH(CRTC_REGS)) u_crtc (
        .clk (clk), .rst_n (rst_n), .req (crtc_req), .rdata (crtc_q)
    );
    vidreg_bank #(.DEPTH(SEQUENCER_REGS)) u_seq (
        .clk (clk), .rst_n (rst_n), .req (seq_req), .rdata (seq_q)
    );
    vidreg_bank #(.DEPTH(GRAPHICS_REGS)) u_gfx (
        .clk (clk), .rst_n (rst_n), .req (gfx_req), .rdata (gfx_q)
    );
    vidreg_bank #(.DEPTH(ATTRIBUTE_REGS)) u_attr (
        .clk (clk), .rst_n (rst_n), .req (attr_req), .rdata (attr_q)
    );

    // Remainder unit is started once the tripled delta has the credit added.
    always_comb
    begin
        rem_cmd.start    = (state_reg == S_CREDIT);
        rem_cmd.dividend = wide_reg + DIVIDEND_W'(credit_reg);
        rem_cmd.divisor  = period_eff;
    end

    vidreg_rem u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (rem_cmd),
        .sts   (rem_sts)
    );

    // Port read decode.
    always_comb
    begin
        case (port_reg)
            PORT_STATUS:    read_value = retrace_reg ? STATUS_RETRACE : STATUS_ACTIVE;
            PORT_ATTR_IDX:  read_value = expect_index_reg ? BYTE_W'(attr_sel_reg)
                                                          : UNOWNED_READ;
            PORT_ATTR_DATA: read_value = attr_q;
            PORT_MISC_WR:   read_value = ZERO_BYTE;
            PORT_SEQ_IDX:   read_value = seq_sel_reg;
            PORT_SEQ_DATA:  read_value = seq_q;
            PORT_MISC_RD:   read_value = misc_reg;
            PORT_GFX_IDX:   read_value = gfx_sel_reg;
            PORT_GFX_DATA:  read_value = gfx_q;
            PORT_CRTC_IDX:  read_value = crtc_sel_reg;
            PORT_CRTC_DATA: read_value = crtc_q;
            default:        read_value = UNOWNED_READ;
        endcase
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.op)
                        OP_READ, OP_WRITE: state_next = S_ACCESS;
                        OP_TICK:           state_next = S_DELTA;
                        default:           state_next = S_RESP;
                    endcase
                end
            end
            S_ACCESS: state_next = S_RESP;
            S_DELTA:  state_next = S_TRIPLE;
            S_TRIPLE: state_next = S_CREDIT;
            S_CREDIT: state_next = S_DIVIDE;
            S_DIVIDE:
            begin
                if (rem_sts.done)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            period_reg       <= FRAME_PERIOD_RST;
            window_reg       <= RETRACE_WINDOW_RST;
            crtc_sel_reg     <= '0;
            seq_sel_reg      <= '0;
            gfx_sel_reg      <= '0;
            attr_sel_reg     <= '0;
            expect_index_reg <= 1'b1;
            misc_reg         <= '0;
            retrace_reg      <= 1'b0;
            last_cycle_reg   <= '0;
            credit_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes; indexes past the list are ignored.
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_PERIOD:   period_reg <= cfg_data;
                    CFG_RETRACE_WINDOW: window_reg <= cfg_data;
                    default:            ;
                endcase
            end

            // Port side effects.
            if (state_reg == S_ACCESS)
            begin
                if (op_reg == OP_READ && port_reg == PORT_STATUS)
                begin
                    expect_index_reg <= 1'b1;
                end
                if (op_reg == OP_WRITE)
                begin
                    case (port_reg)
                        PORT_ATTR_IDX:
                        begin
                            if (expect_index_reg)
                            begin
                                attr_sel_reg <= ATTR_SEL_W'(data_reg & ATTR_INDEX_MASK);
                            end
                            expect_index_reg <= !expect_index_reg;
                        end
                        PORT_MISC_WR:  misc_reg     <= data_reg;
                        PORT_SEQ_IDX:  seq_sel_reg  <= data_reg;
                        PORT_GFX_IDX:  gfx_sel_reg  <= data_reg;
                        PORT_CRTC_IDX: crtc_sel_reg <= data_reg;
                        default:       ;
                    endcase
                end
            end

            // Tick bookkeeping.
            if (state_reg == S_DELTA)
            begin
                last_cycle_reg <= cycle_reg;
            end
            if (state_reg == S_DIVIDE && rem_sts.done)
            begin
                credit_reg  <= rem_sts.remainder;
                retrace_reg <= (rem_sts.remainder < window_reg);
            end

            // Output register.
            if (state_reg == S_RESP && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= req.op;
            port_reg      <= req.port;
            data_reg      <= req.data;
            cycle_reg     <= req.cycle_count;
            res_data_reg  <= ZERO_BYTE;
            res_owned_reg <= 1'b0;
        end
        case (state_reg)
            S_ACCESS:
            begin
                res_owned_reg <= is_owned(port_reg);
                res_data_reg  <= (op_reg == OP_READ) ? read_value : ZERO_BYTE;
            end
            S_DELTA:  wide_reg <= {{(DIVIDEND_W - CYCLE_W){1'b0}}, tick_delta};
            S_TRIPLE: wide_reg <= wide_reg + {wide_reg[DIVIDEND_W-2:0], 1'b0};
            default:  ;
        endcase
        if (state_reg == S_RESP && out_free)
        begin
            out_data_reg  <= res_data_reg;
            out_owned_reg <= res_owned_reg;
        end
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = out_data_reg;
    assign rsp.port_owned = out_owned_reg;

    // One-hot sequencer.
    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
    else $error("sequencer state not one-hot");

    // An accepted transaction keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> !req.ready)
    else $error("new transaction taken while one is in flight");

    // A finished tick leaves the credit reduced below the frame period.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVIDE && rem_sts.done) |=> (credit_reg < period_eff))
    else $error("frame credit not reduced");

    // The retrace flag follows the compare of the new credit with the window.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVIDE && rem_sts.done) |=> (retrace_reg == (credit_reg < window_reg)))
    else $error("retrace flag disagrees with credit");
endmodule

// File: bench/tb_video_adapter_register_file.sv
// Self-checking testbench for the display adapter I/O register file.
`timescale 1ns / 100ps

module tb_video_adapter_register_file;
    import vidreg_pkg::*;

    // The fourth operation code has no meaning in the block and must give an empty reply.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Largest value a 19-bit configuration register can hold.
    localparam logic [PERIOD_W-1:0] REG_MAX = 19'h7FFFF;

    // One port or tick transaction on the request channel.
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [PORT_W-1:0]  port;
        logic [BYTE_W-1:0]  data;
        logic [CYCLE_W-1:0] cycle_count;
    } port_access_t;

    // One reply transaction on the response channel.
    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              port_owned;
    } port_reply_t;

    // Tracks the adapter's registers and retrace timing, and holds the replies still owed.
    class register_file_tracker;
        logic [BYTE_W-1:0]     crtc_bank [CRTC_REGS_DEF];
        logic [BYTE_W-1:0]     seq_bank [SEQUENCER_REGS_DEF];
        logic [BYTE_W-1:0]     gfx_bank [GRAPHICS_REGS_DEF];
        logic [BYTE_W-1:0]     attr_bank [ATTRIBUTE_REGS_DEF];
        logic [BYTE_W-1:0]     crtc_sel;
        logic [BYTE_W-1:0]     seq_sel;
        logic [BYTE_W-1:0]     gfx_sel;
        logic [ATTR_SEL_W-1:0] attr_sel;
        logic                  attr_wants_index;
        logic [BYTE_W-1:0]     misc_out;
        logic                  retrace;
        logic [CYCLE_W-1:0]    last_count;
        logic [PERIOD_W-1:0]   credit;
        logic [PERIOD_W-1:0]   frame_period;
        logic [PERIOD_W-1:0]   retrace_window;
        port_reply_t           expected_replies[$];
        int                    failures;

        function new();
            foreach (crtc_bank[i]) crtc_bank[i] = '0;
            foreach (seq_bank[i]) seq_bank[i] = '0;
            foreach (gfx_bank[i]) gfx_bank[i] = '0;
            foreach (attr_bank[i]) attr_bank[i] = '0;
            crtc_sel = '0;
            seq_sel = '0;
            gfx_sel = '0;
            attr_sel = '0;
            attr_wants_index = 1'b1;
            misc_out = '0;
            retrace = 1'b0;
            last_count = '0;
            credit = '0;
            frame_period = FRAME_PERIOD_RST;
            retrace_window = RETRACE_WINDOW_RST;
            failures = 0;
        endfunction

        function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] value);
            if (idx == CFG_FRAME_PERIOD)
                frame_period = value;
            else if (idx == CFG_RETRACE_WINDOW)
                retrace_window = value;
        endfunction

        // Works out the reply to one accepted transaction and advances the register state.
        function port_reply_t predict_reply(port_access_t a);
            port_reply_t        r;
            logic               owned;
            logic [CYCLE_W-1:0] delta;
            logic [CYCLE_W-1:0] modulus;
            logic [CYCLE_W-1:0] total;
            r = '0;
            case (a.port)
                PORT_ATTR_IDX, PORT_ATTR_DATA, PORT_MISC_WR, PORT_SEQ_IDX, PORT_SEQ_DATA,
                PORT_MISC_RD, PORT_GFX_IDX, PORT_GFX_DATA, PORT_CRTC_IDX, PORT_CRTC_DATA,
                PORT_STATUS: owned = 1'b1;
                default: owned = 1'b0;
            endcase
            case (a.op)
                OP_READ:
                begin
                    r.port_owned = owned;
                    case (a.port)
                        PORT_STATUS:
                        begin
                            attr_wants_index = 1'b1;
                            r.read_data = retrace ? STATUS_RETRACE : STATUS_ACTIVE;
                        end
                        PORT_ATTR_IDX:
                            r.read_data = attr_wants_index ? BYTE_W'(attr_sel) : UNOWNED_READ;
                        PORT_ATTR_DATA: r.read_data = attr_bank[attr_sel];
                        PORT_MISC_WR:   r.read_data = ZERO_BYTE;
                        PORT_SEQ_IDX:   r.read_data = seq_sel;
                        PORT_SEQ_DATA:  r.read_data = seq_bank[seq_sel % SEQUENCER_REGS_DEF];
                        PORT_MISC_RD:   r.read_data = misc_out;
                        PORT_GFX_IDX:   r.read_data = gfx_sel;
                        PORT_GFX_DATA:  r.read_data = gfx_bank[gfx_sel % GRAPHICS_REGS_DEF];
                        PORT_CRTC_IDX:  r.read_data = crtc_sel;
                        PORT_CRTC_DATA: r.read_data = crtc_bank[crtc_sel % CRTC_REGS_DEF];
                        default:        r.read_data = UNOWNED_READ;
                    endcase
                end
                OP_WRITE:
                begin
                    r.port_owned = owned;
                    case (a.port)
                        PORT_ATTR_IDX:
                        begin
                            if (attr_wants_index)
                                attr_sel = ATTR_SEL_W'(a.data & ATTR_INDEX_MASK);
                            else
                                attr_bank[attr_sel] = a.data;
                            attr_wants_index = !attr_wants_index;
                        end
                        PORT_MISC_WR:   misc_out = a.data;
                        PORT_SEQ_IDX:   seq_sel = a.data;
                        PORT_SEQ_DATA:  seq_bank[seq_sel % SEQUENCER_REGS_DEF] = a.data;
                        PORT_GFX_IDX:   gfx_sel = a.data;
                        PORT_GFX_DATA:  gfx_bank[gfx_sel % GRAPHICS_REGS_DEF] = a.data;
                        PORT_CRTC_IDX:  crtc_sel = a.data;
                        PORT_CRTC_DATA: crtc_bank[crtc_sel % CRTC_REGS_DEF] = a.data;
                        default: ;
                    endcase
                end
                OP_TICK:
                begin
                    // A zero period behaves as a period of one.
                    delta = a.cycle_count - last_count;
                    modulus = (frame_period == '0) ? 64'd1 : CYCLE_W'(frame_period);
                    last_count = a.cycle_count;
                    total = (CYCLE_W'(credit) % modulus) + 64'd3 * (delta % modulus);
                    credit = PERIOD_W'(total % modulus);
                    retrace = credit < retrace_window;
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_access(port_access_t a);
            expected_replies.push_back(predict_reply(a));
        endfunction

        function void check_reply(port_reply_t got);
            port_reply_t want;
            if (expected_replies.size() == 0)
            begin
                $error("reply with no transaction pending: read_data %h port_owned %b",
                       got.read_data, got.port_owned);
                failures++;
                return;
            end
            want = expected_replies.pop_front();
            if (got.read_data !== want.read_data)
            begin
                $error("read_data mismatch: expected %h, actual %h",
                       want.read_data, got.read_data);
                failures++;
            end
            if (got.port_owned !== want.port_owned)
            begin
                $error("port_owned mismatch: expected %b, actual %b",
                       want.port_owned, got.port_owned);
                failures++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [PERIOD_W-1:0]   cfg_data;

    vidreg_req_if req_ch ();
    vidreg_rsp_if rsp_ch ();

    register_file_tracker tracker = new();

    logic [PORT_W-1:0] owned_ports [11] = '{
        PORT_ATTR_IDX, PORT_ATTR_DATA, PORT_MISC_WR, PORT_SEQ_IDX, PORT_SEQ_DATA,
        PORT_MISC_RD, PORT_GFX_IDX, PORT_GFX_DATA, PORT_CRTC_IDX, PORT_CRTC_DATA,
        PORT_STATUS
    };

    int                 sent_count = 0;
    int                 burst_left = 0;
    int                 receiver_hold = 0;
    logic [CYCLE_W-1:0] tick_clock = '0;

    video_adapter_register_file uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard limit on the length of the run.
    initial
    begin
        #2000000;
        $display("video_adapter_register_file verification failed");
        $finish;
    end

    // Monitor: every handshake and register write is seen at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                tracker.apply_config(cfg_index, cfg_data);
            if (req_ch.valid && req_ch.ready)
                tracker.note_access({req_ch.op, req_ch.port, req_ch.data, req_ch.cycle_count});
            if (rsp_ch.valid && rsp_ch.ready)
                tracker.check_reply({rsp_ch.read_data, rsp_ch.port_owned});
        end
    end

    // Response side: stalls follow a rotating mask that changes now and then,
    // and a long hold-off can be requested by the stimulus.
    initial
    begin
        logic [15:0] stall_mask;
        int          mask_age;
        int          mask_pos;
        stall_mask = 16'hFFFF;
        mask_age = 0;
        mask_pos = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (receiver_hold > 0)
            begin
                rsp_ch.ready = 1'b0;
                receiver_hold--;
            end
            else
            begin
                if (mask_age == 0)
                begin
                    stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                            : (16'($urandom) | 16'h0001);
                    mask_age = $urandom_range(50, 300);
                end
                rsp_ch.ready = stall_mask[mask_pos];
                mask_pos = (mask_pos + 1) % 16;
                mask_age--;
            end
        end
    end

    // Offers one transaction, with burst gaps in front of it, and returns once it is taken.
    task automatic send_access(input logic [OP_W-1:0] op, input logic [PORT_W-1:0] port,
                               input logic [BYTE_W-1:0] data,
                               input logic [CYCLE_W-1:0] count);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                req_ch.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        req_ch.valid = 1'b1;
        req_ch.op = op;
        req_ch.port = port;
        req_ch.data = data;
        req_ch.cycle_count = count;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sent_count++;
    endtask

    // Drops the request and waits until every reply has come back and the block is quiet.
    task automatic settle_idle();
        @(negedge clk);
        req_ch.valid = 1'b0;
        burst_left = 0;
        while (tracker.expected_replies.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // Writes both timing registers on consecutive cycles.
    task automatic program_timing(input logic [PERIOD_W-1:0] period,
                                  input logic [PERIOD_W-1:0] window);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = CFG_FRAME_PERIOD;
        cfg_data = period;
        @(negedge clk);
        cfg_index = CFG_RETRACE_WINDOW;
        cfg_data = window;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Picks the next tick count: mostly forward steps on the scale of the frame period,
    // with repeats, small steps, backward steps and arbitrary jumps mixed in.
    function automatic logic [CYCLE_W-1:0] next_tick_count();
        int unsigned scale;
        int          pick;
        scale = (tracker.frame_period == '0) ? 1000 : int'(tracker.frame_period);
        pick = $urandom_range(0, 99);
        if (pick < 60)
            tick_clock = tick_clock + $urandom_range(1, scale);
        else if (pick < 75)
            tick_clock = tick_clock + $urandom_range(0, 16);
        else if (pick < 85)
            tick_clock = tick_clock;
        else if (pick < 95)
            tick_clock = {$urandom, $urandom};
        else
            tick_clock = tick_clock - $urandom_range(1, 5000);
        return tick_clock;
    endfunction

    // Select an entry of one indexed bank, write it and read it back.
    task automatic bank_sequence(input logic [PORT_W-1:0] index_port,
                                 input logic [PORT_W-1:0] data_port);
        logic [BYTE_W-1:0] sel;
        sel = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
        send_access(OP_WRITE, index_port, sel, {$urandom, $urandom});
        if ($urandom_range(0, 3) != 0)
            send_access(OP_WRITE, data_port, 8'($urandom), {$urandom, $urandom});
        send_access(OP_READ, data_port, 8'($urandom), {$urandom, $urandom});
        if ($urandom_range(0, 9) < 3)
            send_access(OP_READ, index_port, 8'($urandom), {$urandom, $urandom});
    endtask

    // Attribute access: usually resync the flip-flop, then index, data and read-backs.
    task automatic attribute_sequence();
        if ($urandom_range(0, 9) < 7)
            send_access(OP_READ, PORT_STATUS, 8'($urandom), {$urandom, $urandom});
        send_access(OP_WRITE, PORT_ATTR_IDX, 8'($urandom), {$urandom, $urandom});
        if ($urandom_range(0, 3) != 0)
            send_access(OP_WRITE, PORT_ATTR_IDX, 8'($urandom), {$urandom, $urandom});
        send_access(OP_READ, PORT_ATTR_DATA, 8'($urandom), {$urandom, $urandom});
        send_access(OP_READ, PORT_ATTR_IDX, 8'($urandom), {$urandom, $urandom});
    endtask

    // Random mix of transactions until the goal count is reached.
    task automatic random_traffic(input int goal, input bit long_hold);
        int pick;
        bit hold_done;
        hold_done = 1'b0;
        while (sent_count < goal)
        begin
            // One long receiver hold-off per phase that asks for it.
            if (long_hold && !hold_done && goal - sent_count <= 160)
            begin
                receiver_hold = 600;
                hold_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 20)
            begin
                case ($urandom_range(0, 2))
                    0: bank_sequence(PORT_SEQ_IDX, PORT_SEQ_DATA);
                    1: bank_sequence(PORT_GFX_IDX, PORT_GFX_DATA);
                    default: bank_sequence(PORT_CRTC_IDX, PORT_CRTC_DATA);
                endcase
            end
            else if (pick < 35)
                attribute_sequence();
            else if (pick < 55)
            begin
                send_access(OP_TICK, 16'($urandom), 8'($urandom), next_tick_count());
                send_access(OP_READ, PORT_STATUS, 8'($urandom), {$urandom, $urandom});
            end
            else if (pick < 80)
                send_access($urandom_range(0, 1) ? OP_WRITE : OP_READ,
                            owned_ports[$urandom_range(0, 10)], 8'($urandom),
                            {$urandom, $urandom});
            else
                send_access(OP_W'($urandom_range(0, 3)), 16'($urandom), 8'($urandom),
                            {$urandom, $urandom});
        end
    endtask

    // Main stimulus.
    initial
    begin
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] window;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_FRAME_PERIOD;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.op = OP_READ;
        req_ch.port = '0;
        req_ch.data = '0;
        req_ch.cycle_count = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: status and attribute flip-flop, index masking and bank wrap.
        send_access(OP_READ, PORT_STATUS, 8'h00, 64'd0);
        send_access(OP_READ, PORT_ATTR_IDX, 8'h00, 64'd0);
        send_access(OP_WRITE, PORT_ATTR_IDX, 8'hFF, 64'd0);
        send_access(OP_READ, PORT_ATTR_IDX, 8'h00, 64'd0);
        send_access(OP_WRITE, PORT_ATTR_IDX, 8'hA5, 64'd0);
        send_access(OP_READ, PORT_ATTR_DATA, 8'h00, 64'd0);
        send_access(OP_WRITE, PORT_SEQ_IDX, 8'hFF, 64'd0);
        send_access(OP_WRITE, PORT_SEQ_DATA, 8'h5A, 64'd0);
        send_access(OP_READ, PORT_SEQ_DATA, 8'h00, 64'd0);
        send_access(OP_WRITE, PORT_GFX_IDX, 8'h80, 64'd0);
        send_access(OP_READ, PORT_GFX_DATA, 8'h00, 64'd0);
        send_access(OP_WRITE, PORT_CRTC_IDX, 8'h3F, 64'd0);
        send_access(OP_WRITE, PORT_CRTC_DATA, 8'hC3, 64'd0);
        send_access(OP_READ, PORT_CRTC_DATA, 8'h00, 64'd0);
        send_access(OP_WRITE, PORT_MISC_WR, 8'h67, 64'd0);
        send_access(OP_READ, PORT_MISC_RD, 8'h00, 64'd0);
        send_access(OP_READ, PORT_MISC_WR, 8'h00, 64'd0);
        // Writes to owned ports that have no write effect.
        send_access(OP_WRITE, PORT_ATTR_DATA, 8'hFF, 64'd0);
        send_access(OP_WRITE, PORT_MISC_RD, 8'hFF, 64'd0);
        send_access(OP_WRITE, PORT_STATUS, 8'hFF, 64'd0);
        // Unowned ports at both ends of the address range.
        send_access(OP_READ, 16'h0000, 8'h00, 64'd0);
        send_access(OP_WRITE, 16'hFFFF, 8'hFF, 64'd0);
        // Ticks: zero delta, largest delta, then a wrap of the cycle count.
        send_access(OP_TICK, 16'h0000, 8'h00, 64'd0);
        send_access(OP_TICK, 16'hFFFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(OP_TICK, 16'h0000, 8'h00, 64'd3000);
        send_access(OP_READ, PORT_STATUS, 8'h00, 64'd0);
        send_access(OP_UNUSED, PORT_STATUS, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
        tick_clock = 64'd3000;

        // Random phases, each under its own timing setting; the first keeps reset values.
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase > 0)
            begin
                settle_idle();
                case (phase)
                    1: begin period = 19'd1;   window = '0;      end
                    2: begin period = REG_MAX; window = REG_MAX; end
                    3: begin period = '0;      window = 19'd1;   end
                    4: begin period = 19'd1000; window = 19'd100; end
                    default:
                    begin
                        period = PERIOD_W'($urandom_range(1, 524287));
                        window = PERIOD_W'($urandom_range(0, int'(period)));
                    end
                endcase
                program_timing(period, window);
            end
            random_traffic(sent_count + 205, phase == 1 || phase == 4);
        end

        settle_idle();
        if (tracker.failures == 0)
            $display("video_adapter_register_file verification clean");
        else
            $display("video_adapter_register_file verification failed");
        $finish;
    end

endmodule

// File: video_adapter_register_file.f
design/vidreg_pkg.sv
design/vidreg_if.sv
design/vidreg_ram.sv
design/vidreg_bank.sv
design/vidreg_rem.sv
design/video_adapter_register_file.sv
bench/tb_video_adapter_register_file.sv
